FILE: src/llht_pkg.sv
// Shared types, widths and constants for the least loaded host table.
`timescale 1ns / 1ps
`default_nettype none

package llht_pkg;

    localparam int ADDR_W = 32;
    localparam int LOAD_W = 16;

    // Input request packing (tdata, lowest bit first)
    localparam int S_IP_LSB   = 0;
    localparam int S_LOAD_LSB = S_IP_LSB + ADDR_W;
    localparam int S_REQ_BIT  = S_LOAD_LSB + LOAD_W;
    localparam int S_DATA_W   = ((S_REQ_BIT + 1 + 7) / 8) * 8;

    // Result packing (tdata, lowest bit first)
    localparam int M_IP_LSB  = 0;
    localparam int M_ANS_BIT = M_IP_LSB + ADDR_W;
    localparam int M_REJ_BIT = M_ANS_BIT + 1;
    localparam int M_DATA_W  = ((M_REJ_BIT + 1 + 7) / 8) * 8;

    // 0.6 in unsigned Q4.12, rounded to nearest
    localparam logic [LOAD_W-1:0] THRESH_RESET = 16'd2458;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LOAD_W-1:0] load_t;

    // One candidate in the minimum search
    typedef struct packed {
        logic  valid;
        load_t load;
        addr_t addr;
    } cand_t;

    // Keep the left (lower-numbered) candidate unless it is invalid or the right one is strictly lower
    function automatic cand_t cand_pick(input cand_t left, input cand_t right);
        cand_t res;
        res = left;
        if (!left.valid) begin
            res = right;
        end else if (right.valid && (right.load < left.load)) begin
            res = right;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/least_loaded_host_table_core.sv
// Top level of the least loaded host table: stream channels, pipeline and config register.
//
// Usage:
//   Input channel s_*: one request per host report carrying the host address,
//   its Q4.12 bandwidth usage and a migration request flag.
//   Result channel m_*: exactly one result per request, in request order,
//   holding the chosen target address, the answered flag and the reject flag.
//   Configuration: cfg_wr_en/cfg_wr_data write the usage threshold; change it
//   only while no request is in flight.
// Pipeline: a request accepted on s_* passes through three registers (input
//   register, table update register, result register) before its result shows on m_*.
// Throughput: one request per cycle while m_* does not stall, as the table update
//   lands before the next request's address match reads the table.
// Reset: aresetn low empties the pipeline, frees every table slot and loads
//   the threshold with 0.6 (2458 in Q4.12).
// Stall: when m_tready is low the result is held; stages behind it keep
//   filling until the pipeline is full, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_host_table_core
    import llht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // host_ip[31:0], usage[47:32], migrate_request[48], zero fill[55:49]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // target_ip[31:0], answered[32], update_rejected[33], zero fill[39:34]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_wr_en,
    input  wire logic [LOAD_W-1:0]   cfg_wr_data
);

    // Stage A: registered request
    logic  a_valid_reg;
    addr_t a_addr_reg;
    load_t a_load_reg;
    logic  a_req_reg;

    // Stage B: request after its table update
    logic  b_valid_reg;
    addr_t b_addr_reg;
    logic  b_req_reg;
    logic  b_rej_reg;

    // Result register
    logic  o_valid_reg;
    addr_t o_target_reg;
    logic  o_answered_reg;
    logic  o_rejected_reg;

    load_t thresh_reg;

    logic  o_ready;
    logic  b_ready;
    logic  a_ready;
    logic  a_move;
    logic  b_move;
    logic  s_take;

    logic [TABLE_ENTRIES-1:0][ADDR_W-1:0] entry_addr;
    logic [TABLE_ENTRIES-1:0][LOAD_W-1:0] entry_load;
    logic                                 a_rejected;
    addr_t                                pick_target;

    // Per-stage flow control
    assign o_ready  = !o_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_move   = a_valid_reg && b_ready;
    assign b_move   = b_valid_reg && o_ready;
    assign s_take   = s_tvalid && a_ready;
    assign s_tready = a_ready;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // Table update happens as a request leaves stage A
    llht_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd_en       (a_move),
        .upd_addr     (a_addr_reg),
        .upd_load     (a_load_reg),
        .entry_addr   (entry_addr),
        .entry_load   (entry_load),
        .upd_rejected (a_rejected)
    );

    // Selection reads the table as left by the request in stage B
    llht_pick #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_pick (
        .entry_addr (entry_addr),
        .entry_load (entry_load),
        .threshold  (thresh_reg),
        .requester  (b_addr_reg),
        .target     (pick_target)
    );

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_addr_reg <= s_tdata[S_IP_LSB +: ADDR_W];
            a_load_reg <= s_tdata[S_LOAD_LSB +: LOAD_W];
            a_req_reg  <= s_tdata[S_REQ_BIT];
        end
        if (a_move) begin
            b_addr_reg <= a_addr_reg;
            b_req_reg  <= a_req_reg;
            b_rej_reg  <= a_rejected;
        end
        if (b_move) begin
            o_target_reg   <= b_req_reg ? pick_target : '0;
            o_answered_reg <= b_req_reg;
            o_rejected_reg <= b_rej_reg;
        end
    end

    // Drive result channel
    always_comb begin
        m_tdata                        = '0;
        m_tdata[M_IP_LSB +: ADDR_W]    = o_target_reg;
        m_tdata[M_ANS_BIT]             = o_answered_reg;
        m_tdata[M_REJ_BIT]             = o_rejected_reg;
    end
    assign m_tvalid = o_valid_reg;

endmodule

`default_nettype wire

FILE: src/llht_store.sv
// Host table storage: address match, slot allocation and load update.
`timescale 1ns / 1ps
`default_nettype none

module llht_store
    import llht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              upd_en,
    input  wire addr_t                             upd_addr,
    input  wire load_t                             upd_load,
    output logic [TABLE_ENTRIES-1:0][ADDR_W-1:0]   entry_addr,
    output logic [TABLE_ENTRIES-1:0][LOAD_W-1:0]   entry_load,
    output logic                                   upd_rejected
);

    logic [TABLE_ENTRIES-1:0][ADDR_W-1:0] addr_reg;
    logic [TABLE_ENTRIES-1:0][LOAD_W-1:0] load_reg;
    logic [TABLE_ENTRIES-1:0]             hit;
    logic [TABLE_ENTRIES-1:0]             free;
    logic [TABLE_ENTRIES-1:0]             first_free;
    logic                                 addr_zero;
    logic                                 any_hit;
    logic                                 any_free;

    // Match and free-slot detection; filled slots always form a prefix
    always_comb begin
        addr_zero = (upd_addr == '0);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            hit[k]  = !addr_zero && (addr_reg[k] == upd_addr);
            free[k] = (addr_reg[k] == '0);
            if (k == 0) begin
                first_free[k] = free[k];
            end else begin
                first_free[k] = free[k] && !free[k-1];
            end
        end
        any_hit      = |hit;
        any_free     = |free;
        upd_rejected = addr_zero || (!any_hit && !any_free);
    end

    // Update a matching entry, or claim the first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            load_reg <= '0;
        end else if (upd_en && !addr_zero) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (hit[k]) begin
                    load_reg[k] <= upd_load;
                end else if (!any_hit && first_free[k]) begin
                    addr_reg[k] <= upd_addr;
                    load_reg[k] <= upd_load;
                end
            end
        end
    end

    assign entry_addr = addr_reg;
    assign entry_load = load_reg;

endmodule

`default_nettype wire

FILE: src/llht_pick.sv
// Least loaded host selection: comparison tree over filled entries plus threshold test.
`timescale 1ns / 1ps
`default_nettype none

module llht_pick
    import llht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
) (
    input  wire logic [TABLE_ENTRIES-1:0][ADDR_W-1:0] entry_addr,
    input  wire logic [TABLE_ENTRIES-1:0][LOAD_W-1:0] entry_load,
    input  wire load_t                                threshold,
    input  wire addr_t                                requester,
    output addr_t                                     target
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    cand_t node [NODES];
    cand_t best;

    // Heap-ordered tree: leaves in slot order, left child wins ties
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            if (i < TABLE_ENTRIES) begin
                node[LEAVES-1+i].valid = (entry_addr[i] != '0);
                node[LEAVES-1+i].load  = entry_load[i];
                node[LEAVES-1+i].addr  = entry_addr[i];
            end else begin
                node[LEAVES-1+i] = '0;
            end
        end
        for (int n = LEAVES - 2; n >= 0; n--) begin
            node[n] = cand_pick(node[2*n+1], node[2*n+2]);
        end
        best = node[0];
    end

    // Offer the least loaded host only when strictly below the threshold
    assign target = (best.valid && (best.load < threshold)) ? best.addr : requester;

endmodule

`default_nettype wire

FILE: src/llht_checker.sv
// Port-level checks for the least loaded host table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module llht_checker
    import llht_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Unanswered results carry a zero target
    a_no_req_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_ANS_BIT]) |-> (m_tdata[M_IP_LSB +: ADDR_W] == '0))
        else $error("target set without a migration request");

    // An empty result register never blocks new requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // Stalled result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind least_loaded_host_table_core llht_checker u_llht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

FILE: dv/least_loaded_host_table_core_tb.sv
// Self-checking testbench for the least loaded host table core.
`timescale 1ns / 1ps

module least_loaded_host_table_core_tb;
    import llht_pkg::*;

    localparam int HOSTS     = 4;
    localparam int PIPE_LAT  = 3;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_LEN = 80;
    localparam int PHASES    = 5;

    // Fixed host addresses used to fill the table in the directed part
    localparam addr_t HOST_A = 32'h0A00_0001;
    localparam addr_t HOST_B = 32'hFFFF_FFFF;
    localparam addr_t HOST_C = 32'h0A00_0002;
    localparam addr_t HOST_D = 32'h8000_0000;
    localparam addr_t HOST_E = 32'h1234_5678;
    localparam addr_t NO_ADDR = 32'h0000_0000;

    typedef struct packed {
        addr_t target;
        logic  answered;
        logic  rejected;
    } host_result_t;

    typedef struct packed {
        addr_t        ip;
        load_t        load;
        logic         req;
        logic         fixed;
        host_result_t want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_wr_en;
    logic [LOAD_W-1:0]   cfg_wr_data;

    // Shadow of the host table and the threshold register
    addr_t host_addr [HOSTS];
    load_t host_load [HOSTS];
    load_t thresh_model;

    host_result_t pending_results [$];
    stim_row_t    directed_rows [$];

    int   fail_count;
    int   results_seen;
    logic tx_idle_on;
    logic rx_idle_on;
    logic long_hold_req;

    least_loaded_host_table_core #(
        .TABLE_ENTRIES(HOSTS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Store the report and pick the migration target for one request
    function automatic host_result_t host_table_apply(addr_t ip, load_t load, logic req);
        host_result_t r;
        logic         stored;
        addr_t        best_addr;
        load_t        best_load;
        int           k;
        stored = 1'b0;
        if (ip != NO_ADDR) begin
            for (k = 0; k < HOSTS; k++) begin
                if (!stored && host_addr[k] == ip) begin
                    host_load[k] = load;
                    stored = 1'b1;
                end
            end
            for (k = 0; k < HOSTS; k++) begin
                if (!stored && host_addr[k] == NO_ADDR) begin
                    host_addr[k] = ip;
                    host_load[k] = load;
                    stored = 1'b1;
                end
            end
        end
        r.target   = NO_ADDR;
        r.answered = req;
        r.rejected = !stored;
        if (req) begin
            r.target = ip;
            if (host_addr[0] != NO_ADDR) begin
                best_addr = host_addr[0];
                best_load = host_load[0];
                // Filled slots form a prefix; keep the first on ties
                for (k = 1; k < HOSTS && host_addr[k] != NO_ADDR; k++) begin
                    if (host_load[k] < best_load) begin
                        best_load = host_load[k];
                        best_addr = host_addr[k];
                    end
                end
                if (best_load < thresh_model) r.target = best_addr;
            end
        end
        return r;
    endfunction

    function automatic int draw_gap(logic enabled);
        if (!enabled) return 0;
        return $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 15));
    endfunction

    function automatic void add_row(addr_t ip, load_t load, logic req, logic fixed,
                                    addr_t tgt, logic ans, logic rej);
        stim_row_t r;
        r.ip            = ip;
        r.load          = load;
        r.req           = req;
        r.fixed         = fixed;
        r.want.target   = tgt;
        r.want.answered = ans;
        r.want.rejected = rej;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: result %0d: %s got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
        fail_count++;
    endtask

    // Offer one request after a random gap when idle gaps are enabled; predict it once accepted
    task automatic send_report(addr_t ip, load_t load, logic req, logic fixed,
                               host_result_t want);
        logic [S_DATA_W-1:0] word;
        host_result_t        guess;
        int                  gap;
        gap = draw_gap(tx_idle_on);
        word = '0;
        word[S_IP_LSB +: ADDR_W]   = ip;
        word[S_LOAD_LSB +: LOAD_W] = load;
        word[S_REQ_BIT]            = req;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        guess = host_table_apply(ip, load, req);
        pending_results.push_back(fixed ? want : guess);
    endtask

    // Hold until every expected result has come back and the pipeline is empty
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_threshold(load_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        thresh_model = value;
    endtask

    task automatic check_result(logic [M_DATA_W-1:0] word);
        host_result_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", 64'(word), '0);
        end else begin
            want = pending_results.pop_front();
            if (word[M_IP_LSB +: ADDR_W] !== want.target)
                report_mismatch("target_ip", 64'(word[M_IP_LSB +: ADDR_W]),
                                64'(want.target));
            if (word[M_ANS_BIT] !== want.answered)
                report_mismatch("answered", 64'(word[M_ANS_BIT]), 64'(want.answered));
            if (word[M_REJ_BIT] !== want.rejected)
                report_mismatch("update_rejected", 64'(word[M_REJ_BIT]),
                                64'(want.rejected));
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(rx_idle_on);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_result(m_tdata);
        end
    end

    // Main sequence: reset, directed table, then random phases per threshold
    initial begin
        load_t        phase_thresh [PHASES];
        stim_row_t    row;
        host_result_t none;
        addr_t        known [4];
        addr_t        ip;
        load_t        load;
        logic         req;
        int           sel;
        int           near;
        int           p;
        int           i;

        fail_count    = 0;
        results_seen  = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        long_hold_req = 1'b0;
        none          = '0;
        thresh_model  = THRESH_RESET;
        for (i = 0; i < HOSTS; i++) begin
            host_addr[i] = NO_ADDR;
            host_load[i] = '0;
        end
        aresetn     <= 1'b0;
        s_tdata     <= '0;
        s_tvalid    <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero address on an empty table, then fill, tie, threshold edge, full table
        add_row(NO_ADDR, 16'h0000, 1'b1, 1'b1, NO_ADDR, 1'b1, 1'b1);
        add_row(NO_ADDR, 16'hFFFF, 1'b0, 1'b1, NO_ADDR, 1'b0, 1'b1);
        add_row(HOST_A,  16'h1000, 1'b1, 1'b1, HOST_A,  1'b1, 1'b0);
        add_row(HOST_B,  16'h0000, 1'b0, 1'b1, NO_ADDR, 1'b0, 1'b0);
        add_row(HOST_C,  16'd2457, 1'b1, 1'b1, HOST_B,  1'b1, 1'b0);
        add_row(HOST_B,  16'd2458, 1'b1, 1'b1, HOST_C,  1'b1, 1'b0);
        add_row(HOST_C,  16'd2458, 1'b1, 1'b1, HOST_C,  1'b1, 1'b0);
        add_row(HOST_D,  16'hFFFF, 1'b0, 1'b1, NO_ADDR, 1'b0, 1'b0);
        add_row(HOST_E,  16'h0000, 1'b1, 1'b1, HOST_E,  1'b1, 1'b1);
        add_row(HOST_D,  16'h0000, 1'b1, 1'b1, HOST_D,  1'b1, 1'b0);
        add_row(HOST_A,  16'h0000, 1'b1, 1'b1, HOST_A,  1'b1, 1'b0);
        add_row(NO_ADDR, 16'h0000, 1'b1, 1'b1, HOST_A,  1'b1, 1'b1);
        add_row(HOST_B,  16'h5A5A, 1'b1, 1'b0, NO_ADDR, 1'b0, 1'b0);
        add_row(32'h0000_0001, 16'hA5A5, 1'b0, 1'b0, NO_ADDR, 1'b0, 1'b0);
        add_row(HOST_A,  16'hFFFF, 1'b1, 1'b0, NO_ADDR, 1'b0, 1'b0);
        add_row(HOST_D,  16'h0999, 1'b1, 1'b0, NO_ADDR, 1'b0, 1'b0);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_report(row.ip, row.load, row.req, row.fixed, row.want);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        known[0] = HOST_A;
        known[1] = HOST_B;
        known[2] = HOST_C;
        known[3] = HOST_D;
        phase_thresh[0] = 16'hFFFF;
        phase_thresh[1] = 16'h0000;
        phase_thresh[2] = load_t'($urandom_range(0, 65535));
        phase_thresh[3] = 16'h0001;
        phase_thresh[4] = THRESH_RESET;

        for (p = 0; p < PHASES; p++) begin
            write_threshold(phase_thresh[p]);
            // Phase 2 runs back to back with a long receiver hold-off
            tx_idle_on = (p != 2) && (p != 4);
            rx_idle_on = (p != 2) && (p != 3);
            if (p == 2) long_hold_req = 1'b1;
            for (i = 0; i < PHASE_LEN; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) ip = known[$urandom_range(0, 3)];
                else if (sel < 92) ip = $urandom;
                else ip = NO_ADDR;
                sel = $urandom_range(0, 99);
                if (sel < 40) begin
                    load = load_t'($urandom_range(0, 65535));
                end else if (sel < 85) begin
                    // Land close to the threshold to hit the strict compare
                    near = int'(thresh_model) + int'($urandom_range(0, 8)) - 4;
                    if (near < 0) near = 0;
                    if (near > 65535) near = 65535;
                    load = load_t'(near);
                end else begin
                    load = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                req = ($urandom_range(0, 9) < 6);
                send_report(ip, load, req, 1'b0, none);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (PIPE_LAT + 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("least_loaded_host_table_core_tb: PASS");
        end else begin
            $display("least_loaded_host_table_core_tb: FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("least_loaded_host_table_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/llht_pkg.sv
src/llht_store.sv
src/llht_pick.sv
src/least_loaded_host_table_core.sv
src/llht_checker.sv
dv/least_loaded_host_table_core_tb.sv
